// ----- design/mtdb_pkg.sv -----
// Shared types, codes and mask/geometry functions for the masked tile decoder.
// Used by every module of the block except mtdb_ram; depends on nothing.
package mtdb_pkg;

    localparam int TILE_SIZE    = 32;
    localparam int LIGHT_LEVELS = 16;
    localparam int TABLE_DEPTH  = LIGHT_LEVELS * 256;
    localparam int TABLE_AW     = $clog2(TABLE_DEPTH);
    localparam int QUEUE_DEPTH  = 4;   // power of two
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    // item function codes
    localparam logic [1:0] FUNC_TABLE_WR   = 2'd0;
    localparam logic [1:0] FUNC_TILE_START = 2'd1;
    localparam logic [1:0] FUNC_BYTE       = 2'd2;

    // tile layouts
    localparam logic [2:0] ENC_SQUARE = 3'd0;
    localparam logic [2:0] ENC_TRANS  = 3'd1;
    localparam logic [2:0] ENC_LTRI   = 3'd2;
    localparam logic [2:0] ENC_RTRI   = 3'd3;
    localparam logic [2:0] ENC_LTRAP  = 3'd4;
    localparam logic [2:0] ENC_RTRAP  = 3'd5;

    // mask selectors
    localparam logic [4:0] MASK_WALL       = 5'd1;
    localparam logic [4:0] MASK_LFLOOR     = 5'd2;
    localparam logic [4:0] MASK_RFLOOR     = 5'd3;
    localparam logic [4:0] MASK_LFOL       = 5'd4;
    localparam logic [4:0] MASK_RFOL       = 5'd5;
    localparam logic [4:0] MASK_UTL_FOL    = 5'd6;
    localparam logic [4:0] MASK_TL_FOL     = 5'd7;
    localparam logic [4:0] MASK_LBL_FOL    = 5'd8;
    localparam logic [4:0] MASK_BL_FOL     = 5'd9;
    localparam logic [4:0] MASK_UTR_FOL    = 5'd10;
    localparam logic [4:0] MASK_TR_FOL     = 5'd11;
    localparam logic [4:0] MASK_LBR_FOL    = 5'd12;
    localparam logic [4:0] MASK_BR_FOL     = 5'd13;
    localparam logic [4:0] MASK_UL_FLOOR   = 5'd14;
    localparam logic [4:0] MASK_UR_FLOOR   = 5'd15;
    localparam logic [4:0] MASK_EMPTY      = 5'd18;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEAD,
        PH_PIX,
        PH_TRAIL
    } t_phase;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] table_index;
        logic [7:0]  table_value;
        logic [4:0]  mask_type;
        logic [2:0]  encoding;
        logic [3:0]  light_level;
        logic [7:0]  data_byte;
    } t_in;

    typedef struct packed {
        logic       write_enable;
        logic [4:0] pixel_x;
        logic [4:0] pixel_row;
        logic [7:0] pixel_color;
        logic       tile_end;
        logic       format_error;
    } t_out;

    // work passed from the front end to the table side
    typedef struct packed {
        logic                is_wr;
        logic                we;
        logic [4:0]          x;
        logic [4:0]          row;
        logic [TABLE_AW-1:0] addr;
        logic [7:0]          wdata;
        logic                tile_end;
        logic                fmt_err;
    } t_job;

    typedef struct packed {
        logic [4:0] start;
        logic [5:0] count;
        logic [1:0] lead;
        logic [1:0] trail;
    } t_geom;

    function automatic logic [31:0] ones_hi(input logic [5:0] n);
        return ~(32'hFFFF_FFFF >> n);
    endfunction

    function automatic logic [31:0] ones_lo(input logic [5:0] n);
        return ~(32'hFFFF_FFFF << n);
    endfunction

    function automatic logic [31:0] chk_word(input logic [4:0] t);
        return t[0] ? 32'h5555_5555 : 32'hAAAA_AAAA;
    endfunction

    function automatic logic [5:0] fol_len(input logic [4:0] t);
        logic [4:0] d;
        d = t - 5'd16;
        if (t < 5'd16) begin
            return 6'd32 - {t, 1'b0};
        end
        return {d, 1'b0};
    endfunction

    function automatic logic [31:0] ramp_left(input logic [4:0] t);
        if (t < 5'd16) begin
            return chk_word(t) | ones_lo({t, 1'b0} + 6'd2);
        end
        return 32'hFFFF_FFFF;
    endfunction

    function automatic logic [31:0] ramp_right(input logic [4:0] t);
        if (t < 5'd16) begin
            return chk_word(t) | ones_hi({t, 1'b0} + 6'd2);
        end
        return 32'hFFFF_FFFF;
    endfunction

    // t is the mask word number (31 - row); bit 31 is the row's first column
    function automatic logic [31:0] mask_word(input logic [4:0] mtype, input logic [4:0] t);
        logic       lo;
        logic [4:0] tm;
        logic [4:0] tp;
        lo = t < 5'd16;
        tm = t - 5'd16;
        tp = t + 5'd16;
        unique case (mtype)
            MASK_WALL:     return chk_word(t);
            MASK_LFLOOR:   return ramp_left(t);
            MASK_RFLOOR:   return ramp_right(t);
            MASK_LFOL:     return ones_hi(fol_len(t));
            MASK_RFOL:     return ones_lo(fol_len(t));
            MASK_UTL_FOL:  return lo ? 32'hFFFF_FFFF : ones_hi(fol_len(tm));
            MASK_TL_FOL:   return lo ? ones_hi(fol_len(t)) : 32'h0;
            MASK_LBL_FOL:  return lo ? ones_hi(fol_len(tp)) : 32'hFFFF_FFFF;
            MASK_BL_FOL:   return lo ? 32'h0 : ones_hi(fol_len(t));
            MASK_UTR_FOL:  return lo ? 32'hFFFF_FFFF : ones_lo(fol_len(tm));
            MASK_TR_FOL:   return lo ? ones_lo(fol_len(t)) : 32'h0;
            MASK_LBR_FOL:  return lo ? ones_lo(fol_len(tp)) : 32'hFFFF_FFFF;
            MASK_BR_FOL:   return lo ? 32'h0 : ones_lo(fol_len(t));
            MASK_UL_FLOOR: return lo ? chk_word(t) : ramp_left(tm);
            MASK_UR_FLOOR: return lo ? chk_word(t) : ramp_right(tm);
            default:       return 32'hFFFF_FFFF;
        endcase
    endfunction

    // row layout: first column, pixel count, pad bytes before and after
    function automatic t_geom geom(input logic [2:0] enc, input logic [4:0] row);
        logic       shaped;
        logic       tri_e;
        logic       left_e;
        logic [4:0] ins;
        logic [4:0] rd;
        t_geom      g;
        shaped = (enc >= ENC_LTRI) && (enc <= ENC_RTRAP);
        tri_e  = (enc == ENC_LTRI) || (enc == ENC_RTRI);
        left_e = (enc == ENC_LTRI) || (enc == ENC_LTRAP);
        rd     = row - 5'd15;
        ins    = 5'd0;
        if (shaped) begin
            if (row < 5'd16) begin
                ins = 5'd30 - {row[3:0], 1'b0};
            end else if (tri_e) begin
                ins = {rd[3:0], 1'b0};
            end
        end
        g.count = 6'd32 - {1'b0, ins};
        g.start = left_e ? ins : 5'd0;
        g.lead  = left_e ? {ins[1], 1'b0} : 2'd0;
        g.trail = left_e ? 2'd0 : {ins[1], 1'b0};
        return g;
    endfunction

endpackage

// ----- design/mtdb_ram.sv -----
// Generic single-port RAM with registered read data.
// Stand-alone; width and depth set by parameters.
module mtdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/mtdb_queue.sv -----
// Short FIFO of decoded jobs between the front end and the table side.
// Depends on mtdb_pkg for the job type and depth.
module mtdb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mtdb_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output mtdb_pkg::t_job o_head,
    input  logic          i_pop
);

    mtdb_pkg::t_job r_mem [mtdb_pkg::QUEUE_DEPTH];

    logic [mtdb_pkg::QUEUE_AW-1:0] r_wp;
    logic [mtdb_pkg::QUEUE_AW-1:0] r_rp;
    logic [mtdb_pkg::QUEUE_AW:0]   r_cnt;
    logic [mtdb_pkg::QUEUE_AW-1:0] n_wp;
    logic [mtdb_pkg::QUEUE_AW-1:0] n_rp;
    logic [mtdb_pkg::QUEUE_AW:0]   n_cnt;

    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_full  = r_cnt == (mtdb_pkg::QUEUE_AW + 1)'(mtdb_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rp];

endmodule

// ----- design/mtdb_front.sv -----
// Front end: accepts items, walks the tile layout and mask, builds one job per item.
// Depends on mtdb_pkg for codes, geometry and mask functions.
module mtdb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mtdb_pkg::t_in  i_in_data,
    input  logic           i_full,
    output logic           o_push,
    output mtdb_pkg::t_job o_job
);

    mtdb_pkg::t_phase r_phase;
    mtdb_pkg::t_phase n_phase;
    logic [4:0] r_mask_type, n_mask_type;
    logic [2:0] r_enc, n_enc;
    logic [3:0] r_light, n_light;
    logic [4:0] r_row, n_row;
    logic [5:0] r_col, n_col;
    logic [6:0] r_left, n_left;

    logic            w_acc;
    logic            w_byte;
    logic            w_trans;
    logic            w_row_last;
    logic [5:0]      w_row_inc;
    mtdb_pkg::t_geom w_g_cur;
    mtdb_pkg::t_geom w_g_nxt;
    mtdb_pkg::t_geom w_g_new;
    logic [5:0]      w_avail;
    logic            w_hdr_run;
    logic [7:0]      w_skip;
    logic            w_skip_over;
    logic            w_run_over;
    logic [5:0]      w_col_skip;
    logic [5:0]      w_col_inc;
    logic [5:0]      w_trans_col_n;
    logic [6:0]      w_left_dec;
    logic [4:0]      w_rel;
    logic [31:0]     w_mword;
    logic            w_draw;
    logic            w_fin;
    logic [5:0]      w_light_sel;

    assign w_acc      = i_in_valid && !i_full;
    assign o_in_stall = i_full;
    assign w_byte     = w_acc && (i_in_data.func == mtdb_pkg::FUNC_BYTE)
                        && (r_phase != mtdb_pkg::PH_IDLE);
    assign w_trans    = r_enc == mtdb_pkg::ENC_TRANS;
    assign w_row_last = ((r_enc == mtdb_pkg::ENC_LTRI) || (r_enc == mtdb_pkg::ENC_RTRI))
                        ? (r_row == 5'd30) : (r_row == 5'd31);
    assign w_row_inc  = {1'b0, r_row} + 6'd1;
    assign w_g_cur    = mtdb_pkg::geom(r_enc, r_row);
    assign w_g_nxt    = mtdb_pkg::geom(r_enc, w_row_inc[4:0]);
    assign w_g_new    = mtdb_pkg::geom(i_in_data.encoding, 5'd0);

    // run headers: 1..127 a run of pixels, otherwise a skip of -v columns
    assign w_avail     = 6'd32 - r_col;
    assign w_hdr_run   = (i_in_data.data_byte != 8'd0) && !i_in_data.data_byte[7];
    assign w_skip      = (i_in_data.data_byte == 8'd0) ? 8'd0
                         : 8'(9'd256 - {1'b0, i_in_data.data_byte});
    assign w_skip_over = w_skip > {2'b0, w_avail};
    assign w_run_over  = i_in_data.data_byte > {2'b0, w_avail};
    assign w_col_skip  = r_col + w_skip[5:0];
    assign w_col_inc   = r_col + 6'd1;
    assign w_trans_col_n = r_col[5] ? r_col : w_col_inc;
    assign w_left_dec  = (r_left != 7'd0) ? r_left - 7'd1 : 7'd0;

    // left layouts count mask bits from the first drawn column
    assign w_rel   = w_trans ? r_col[4:0] : 5'(r_col - {1'b0, w_g_cur.start});
    assign w_mword = mtdb_pkg::mask_word(r_mask_type, 5'd31 - r_row);
    assign w_draw  = w_byte && (r_phase == mtdb_pkg::PH_PIX) && !(w_trans && r_col[5])
                     && (r_mask_type != mtdb_pkg::MASK_EMPTY) && w_mword[5'd31 - w_rel];

    assign w_light_sel = (32'(r_light) < 32'(mtdb_pkg::LIGHT_LEVELS))
                         ? {2'b0, r_light} : 6'(mtdb_pkg::LIGHT_LEVELS - 1);

    // end of the current row
    always_comb begin
        w_fin = 1'b0;
        if (w_byte) begin
            if (w_trans) begin
                if (r_phase == mtdb_pkg::PH_LEAD) begin
                    w_fin = !w_hdr_run && (w_skip_over || w_col_skip[5]);
                end else if (r_phase == mtdb_pkg::PH_PIX) begin
                    w_fin = (w_left_dec == 7'd0) && w_trans_col_n[5];
                end
            end else begin
                w_fin = (w_left_dec == 7'd0) && ((r_phase == mtdb_pkg::PH_TRAIL)
                        || ((r_phase == mtdb_pkg::PH_PIX) && (w_g_cur.trail == 2'd0)));
            end
        end
    end

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_mask_type = r_mask_type;
        n_enc       = r_enc;
        n_light     = r_light;
        n_row       = r_row;
        n_col       = r_col;
        n_left      = r_left;
        if (w_acc && (i_in_data.func == mtdb_pkg::FUNC_TILE_START)) begin
            n_mask_type = i_in_data.mask_type;
            n_enc       = i_in_data.encoding;
            n_light     = i_in_data.light_level;
            n_row       = 5'd0;
            n_col       = 6'd0;
            n_left      = 7'd0;
            if (i_in_data.encoding == mtdb_pkg::ENC_TRANS) begin
                n_phase = mtdb_pkg::PH_LEAD;
            end else if (i_in_data.encoding <= mtdb_pkg::ENC_RTRAP) begin
                n_col = {1'b0, w_g_new.start};
                if (w_g_new.lead != 2'd0) begin
                    n_phase = mtdb_pkg::PH_LEAD;
                    n_left  = {5'b0, w_g_new.lead};
                end else begin
                    n_phase = mtdb_pkg::PH_PIX;
                    n_left  = {1'b0, w_g_new.count};
                end
            end else begin
                n_phase = mtdb_pkg::PH_IDLE;
            end
        end else if (w_byte) begin
            if (w_trans) begin
                unique case (r_phase)
                    mtdb_pkg::PH_LEAD: begin
                        if (w_hdr_run) begin
                            n_phase = mtdb_pkg::PH_PIX;
                            n_left  = i_in_data.data_byte[6:0];
                        end else begin
                            n_col = w_skip_over ? 6'd32 : w_col_skip;
                        end
                    end
                    mtdb_pkg::PH_PIX: begin
                        n_col  = w_trans_col_n;
                        n_left = w_left_dec;
                        if (w_left_dec == 7'd0) begin
                            n_phase = mtdb_pkg::PH_LEAD;
                        end
                    end
                    default: ;
                endcase
            end else begin
                n_left = w_left_dec;
                if (r_phase == mtdb_pkg::PH_PIX) begin
                    n_col = w_col_inc;
                end
                if (w_left_dec == 7'd0) begin
                    unique case (r_phase)
                        mtdb_pkg::PH_LEAD: begin
                            n_phase = mtdb_pkg::PH_PIX;
                            n_left  = {1'b0, w_g_cur.count};
                        end
                        mtdb_pkg::PH_PIX: begin
                            if (w_g_cur.trail != 2'd0) begin
                                n_phase = mtdb_pkg::PH_TRAIL;
                                n_left  = {5'b0, w_g_cur.trail};
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (w_fin) begin
                if (w_row_last) begin
                    n_phase = mtdb_pkg::PH_IDLE;
                end else begin
                    n_row = w_row_inc[4:0];
                    if (w_trans) begin
                        n_phase = mtdb_pkg::PH_LEAD;
                        n_col   = 6'd0;
                        n_left  = 7'd0;
                    end else begin
                        n_col = {1'b0, w_g_nxt.start};
                        if (w_g_nxt.lead != 2'd0) begin
                            n_phase = mtdb_pkg::PH_LEAD;
                            n_left  = {5'b0, w_g_nxt.lead};
                        end else begin
                            n_phase = mtdb_pkg::PH_PIX;
                            n_left  = {1'b0, w_g_nxt.count};
                        end
                    end
                end
            end
        end
    end

    // job for the table side
    always_comb begin
        o_push = w_acc;
        o_job  = '0;
        if (i_in_data.func == mtdb_pkg::FUNC_TABLE_WR) begin
            o_job.is_wr = 32'(i_in_data.table_index) < 32'(mtdb_pkg::TABLE_DEPTH);
            o_job.addr  = mtdb_pkg::TABLE_AW'(i_in_data.table_index);
            o_job.wdata = i_in_data.table_value;
        end else begin
            o_job.we       = w_draw;
            o_job.addr     = mtdb_pkg::TABLE_AW'({w_light_sel, i_in_data.data_byte});
            o_job.tile_end = w_fin && w_row_last;
            o_job.fmt_err  = w_byte && w_trans && (r_phase == mtdb_pkg::PH_LEAD)
                             && (w_hdr_run ? w_run_over : w_skip_over);
            if (w_draw) begin
                o_job.x   = r_col[4:0];
                o_job.row = r_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= mtdb_pkg::PH_IDLE;
            r_mask_type <= 5'd0;
            r_enc       <= 3'd0;
            r_light     <= 4'd0;
            r_row       <= 5'd0;
            r_col       <= 6'd0;
            r_left      <= 7'd0;
        end else if (w_acc) begin
            r_phase     <= n_phase;
            r_mask_type <= n_mask_type;
            r_enc       <= n_enc;
            r_light     <= n_light;
            r_row       <= n_row;
            r_col       <= n_col;
            r_left      <= n_left;
        end
    end

endmodule

// ----- design/mtdb_back.sv -----
// Table side: takes jobs from the queue, writes or reads the remap table, holds the result.
// Depends on mtdb_pkg and mtdb_ram.
module mtdb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  mtdb_pkg::t_job i_q_head,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output mtdb_pkg::t_out o_out_data
);

    logic           r_valid;
    mtdb_pkg::t_job r_job;
    logic [7:0]     w_rdata;

    assign o_pop = i_q_valid && (!r_valid || !i_out_stall);

    // read data stays put while the result waits, as the table is only enabled on a pop
    mtdb_ram #(
        .WIDTH (8),
        .DEPTH (mtdb_pkg::TABLE_DEPTH)
    ) u_remap (
        .i_clk   (i_clk),
        .i_en    (o_pop),
        .i_we    (i_q_head.is_wr),
        .i_addr  (i_q_head.addr),
        .i_wdata (i_q_head.wdata),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_head;
        end
    end

    assign o_out_valid               = r_valid;
    assign o_out_data.write_enable   = r_job.we;
    assign o_out_data.pixel_x        = r_job.x;
    assign o_out_data.pixel_row      = r_job.row;
    assign o_out_data.pixel_color    = r_job.we ? w_rdata : 8'd0;
    assign o_out_data.tile_end       = r_job.tile_end;
    assign o_out_data.format_error   = r_job.fmt_err;

endmodule

// ----- design/masked_tile_decoder_blitter.sv -----
// Top level of the masked tile decoder: front end, job queue, table side.
// Depends on mtdb_pkg, mtdb_front, mtdb_queue, mtdb_back.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------
//  in       | receive   | i_in_valid / o_in_stall    | i_in_data  (t_in)
//  out      | send      | o_out_valid / i_out_stall  | o_out_data (t_out)
//
// One item per cycle sustained unless the output stalls, one result per item; each
// result passes the queue register, then the remap table's registered read.
// The single table port serves either a table write or a pixel lookup each cycle.
// Reset is synchronous and clears the sequencer, queue and output valid; table
// contents are undefined until written. An output stall holds the result and the
// table read; the input stalls once the four-entry queue is full.
module masked_tile_decoder_blitter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mtdb_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output mtdb_pkg::t_out o_out_data
);

    logic           w_push;
    mtdb_pkg::t_job w_job;
    logic           w_full;
    logic           w_q_valid;
    mtdb_pkg::t_job w_q_head;
    logic           w_pop;

    mtdb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_job)
    );

    mtdb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_head  (w_q_head),
        .i_pop   (w_pop)
    );

    mtdb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_head    (w_q_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push)
        else $error("job pushed into a full queue");

    a_pop_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_out_valid)
        else $error("popped job did not reach the output");

    a_hold_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !w_pop)
        else $error("table re-read while a result is held");

    a_hdr_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.format_error) |-> !o_out_data.write_enable)
        else $error("run header produced a pixel write");

endmodule

// ----- tb/sv/mtdb_tb_pkg.sv -----
// Result checker for the masked tile decoder testbench: keeps its own copy of the
// decoder state and colour table, works out each item's result and checks results in order.
// Depends on mtdb_pkg.
package mtdb_tb_pkg;
    import mtdb_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [2:0] ENC_BAD_LO  = 3'd6;
    localparam logic [2:0] ENC_BAD_HI  = 3'd7;
    localparam logic [4:0] MASK_SOLID  = 5'd0;
    localparam logic [4:0] MASK_SPARE  = 5'd31;  // unused selector, draws as solid
    localparam int         REPORT_LINES = 50;

    class blit_scoreboard;
        bit [7:0] colour_tbl [TABLE_DEPTH];
        bit       colour_set [TABLE_DEPTH];
        int       colours_per_light [LIGHT_LEVELS];
        bit [4:0] mtype;
        bit [2:0] enc;
        bit [3:0] light;
        int       row;
        int       col;
        int       left;
        t_phase   ph = PH_IDLE;
        t_out     due_pixels [$];
        int       n_seen;
        int       n_bad;

        task report(string msg);
            n_bad++;
            if (n_bad <= REPORT_LINES) $display("%0t ns: %s", $time, msg);
        endtask

        function bit [31:0] low_ones(int n);
            bit [32:0] w;
            w = (33'd1 << n) - 33'd1;
            return w[31:0];
        endfunction

        function bit [31:0] high_ones(int n);
            return low_ones(n) << (32 - n);
        endfunction

        function bit [31:0] stripes(int t);
            return t[0] ? 32'h5555_5555 : 32'hAAAA_AAAA;
        endfunction

        function int fol_len(int t);
            return t < 16 ? 32 - 2 * t : 2 * (t - 16);
        endfunction

        function bit [31:0] ramp(int t, bit to_left);
            if (t >= 16) return 32'hFFFF_FFFF;
            return stripes(t) | (to_left ? low_ones(2 * t + 2) : high_ones(2 * t + 2));
        endfunction

        // t is 31 - row, so it counts from the bottom row; bit 31 is the first drawn column
        function bit [31:0] row_mask(int t);
            bit lo;
            lo = t < 16;
            case (mtype)
                MASK_WALL:     return stripes(t);
                MASK_LFLOOR:   return ramp(t, 1'b1);
                MASK_RFLOOR:   return ramp(t, 1'b0);
                MASK_LFOL:     return high_ones(fol_len(t));
                MASK_RFOL:     return low_ones(fol_len(t));
                MASK_UTL_FOL:  return lo ? 32'hFFFF_FFFF : high_ones(fol_len(t - 16));
                MASK_TL_FOL:   return lo ? high_ones(fol_len(t)) : 32'h0;
                MASK_LBL_FOL:  return lo ? high_ones(fol_len(t + 16)) : 32'hFFFF_FFFF;
                MASK_BL_FOL:   return lo ? 32'h0 : high_ones(fol_len(t));
                MASK_UTR_FOL:  return lo ? 32'hFFFF_FFFF : low_ones(fol_len(t - 16));
                MASK_TR_FOL:   return lo ? low_ones(fol_len(t)) : 32'h0;
                MASK_LBR_FOL:  return lo ? low_ones(fol_len(t + 16)) : 32'hFFFF_FFFF;
                MASK_BR_FOL:   return lo ? 32'h0 : low_ones(fol_len(t));
                MASK_UL_FLOOR: return lo ? stripes(t) : ramp(t - 16, 1'b1);
                MASK_UR_FLOOR: return lo ? stripes(t) : ramp(t - 16, 1'b0);
                default:       return 32'hFFFF_FFFF;
            endcase
        endfunction

        function void shape(output int start, output int count, output int lead,
                            output int trail);
            int ins;
            ins = 0;
            if (enc >= ENC_LTRI && enc <= ENC_RTRAP) begin
                if (row < 16) ins = 30 - 2 * row;
                else if (enc == ENC_LTRI || enc == ENC_RTRI) ins = 2 * (row - 15);
            end
            count = TILE_SIZE - ins;
            if (enc == ENC_LTRI || enc == ENC_LTRAP) begin
                start = ins;
                lead  = ins & 2;
                trail = 0;
            end else begin
                start = 0;
                lead  = 0;
                trail = ins & 2;
            end
        endfunction

        function void open_row();
            int start, count, lead, trail;
            if (enc == ENC_TRANS) begin
                ph   = PH_LEAD;
                col  = 0;
                left = 0;
                return;
            end
            shape(start, count, lead, trail);
            col = start;
            if (lead != 0) begin
                ph   = PH_LEAD;
                left = lead;
            end else begin
                ph   = PH_PIX;
                left = count;
            end
        endfunction

        function void end_row(inout t_out r);
            row++;
            if (row >= ((enc == ENC_LTRI || enc == ENC_RTRI) ? TILE_SIZE - 1 : TILE_SIZE)) begin
                ph         = PH_IDLE;
                r.tile_end = 1'b1;
            end else begin
                open_row();
            end
        endfunction

        function void put_pixel(inout t_out r, input int rel, input bit [7:0] b);
            bit [31:0] m;
            int        l;
            if (mtype == MASK_EMPTY || rel > 31 || row >= TILE_SIZE) return;
            m = row_mask(TILE_SIZE - 1 - row);
            if (!m[31 - rel]) return;
            l = (light < LIGHT_LEVELS) ? light : LIGHT_LEVELS - 1;
            r.write_enable = 1'b1;
            r.pixel_x      = col[4:0];
            r.pixel_row    = row[4:0];
            r.pixel_color  = colour_tbl[(l * 256 + b) % TABLE_DEPTH];
        endfunction

        function void run_byte(inout t_out r, input bit [7:0] b);
            int avail, skip;
            if (ph == PH_LEAD) begin
                avail = TILE_SIZE - col;
                if (b >= 1 && b <= 127) begin
                    if (b > avail) r.format_error = 1'b1;
                    ph   = PH_PIX;
                    left = b;
                end else begin
                    skip = (b == 0) ? 0 : 256 - b;
                    if (skip > avail) begin
                        r.format_error = 1'b1;
                        col = TILE_SIZE;
                    end else begin
                        col += skip;
                    end
                    if (col >= TILE_SIZE) end_row(r);
                end
                return;
            end
            if (col < TILE_SIZE) begin
                put_pixel(r, col, b);
                col++;
            end
            if (left > 0) left--;
            if (left == 0) begin
                if (col >= TILE_SIZE) end_row(r);
                else ph = PH_LEAD;
            end
        endfunction

        function void shaped_byte(inout t_out r, input bit [7:0] b);
            int start, count, lead, trail;
            shape(start, count, lead, trail);
            if (ph == PH_PIX) begin
                put_pixel(r, col - start, b);
                col++;
            end
            if (left > 0) left--;
            if (left != 0) return;
            if (ph == PH_LEAD) begin
                ph   = PH_PIX;
                left = count;
            end else if (ph == PH_PIX && trail != 0) begin
                ph   = PH_TRAIL;
                left = trail;
            end else begin
                end_row(r);
            end
        endfunction

        function t_out blit_item(t_in it);
            t_out r;
            r = '0;
            case (it.func)
                FUNC_TABLE_WR: begin
                    if (it.table_index < TABLE_DEPTH) begin
                        if (!colour_set[it.table_index])
                            colours_per_light[it.table_index / 256]++;
                        colour_set[it.table_index] = 1'b1;
                        colour_tbl[it.table_index] = it.table_value;
                    end
                end
                FUNC_TILE_START: begin
                    mtype = it.mask_type;
                    enc   = it.encoding;
                    light = it.light_level;
                    row   = 0;
                    col   = 0;
                    left  = 0;
                    if (enc <= ENC_RTRAP) open_row();
                    else ph = PH_IDLE;
                end
                FUNC_BYTE: begin
                    if (ph != PH_IDLE) begin
                        if (enc == ENC_TRANS) run_byte(r, it.data_byte);
                        else shaped_byte(r, it.data_byte);
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_item(t_in it);
            due_pixels.push_back(blit_item(it));
        endfunction

        task cmp(string field, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %0h, want %0h", n_seen, field, got, want));
        endtask

        task check_pixel(t_out got);
            t_out want;
            n_seen++;
            if (due_pixels.size() == 0) begin
                report($sformatf("result %0d arrived with none expected: %h", n_seen, got));
                return;
            end
            want = due_pixels.pop_front();
            cmp("write_enable", got.write_enable, want.write_enable);
            cmp("pixel_x", got.pixel_x, want.pixel_x);
            cmp("pixel_row", got.pixel_row, want.pixel_row);
            cmp("pixel_color", got.pixel_color, want.pixel_color);
            cmp("tile_end", got.tile_end, want.tile_end);
            cmp("format_error", got.format_error, want.format_error);
        endtask
    endclass

endpackage

// ----- tb/sv/masked_tile_decoder_blitter_tb.sv -----
// Top of the masked tile decoder testbench: clock, reset, item driver, output stall
// and result monitor around masked_tile_decoder_blitter.
// Depends on mtdb_pkg, mtdb_tb_pkg and the block's RTL.
module masked_tile_decoder_blitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mtdb_pkg::*;
    import mtdb_tb_pkg::*;

    localparam int          N_ITEMS = 1900;
    localparam logic [2:0]  SHAPES [5] = '{ENC_SQUARE, ENC_LTRI, ENC_RTRI, ENC_LTRAP, ENC_RTRAP};

    logic           clk = 1'b0;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    t_in            in_data;
    logic           out_valid;
    logic           out_stall;
    t_out           out_data;
    blit_scoreboard sb;
    int             n_sent = 0;
    int             tile_left = 40;
    bit             hold_on = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    masked_tile_decoder_blitter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // a stretch where neither side idles
    function automatic bit calm();
        return n_sent >= 1000 && n_sent < 1300;
    endfunction

    // every field random; callers set the ones that matter
    function automatic t_in scrambled();
        bit [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[41:0];
    endfunction

    function automatic t_in wr_colour(logic [11:0] idx, logic [7:0] val);
        t_in it;
        it             = scrambled();
        it.func        = FUNC_TABLE_WR;
        it.table_index = idx;
        it.table_value = val;
        return it;
    endfunction

    function automatic t_in start_tile(logic [4:0] mask, logic [2:0] layout, logic [3:0] lvl);
        t_in it;
        it             = scrambled();
        it.func        = FUNC_TILE_START;
        it.mask_type   = mask;
        it.encoding    = layout;
        it.light_level = lvl;
        return it;
    endfunction

    function automatic t_in stream_byte(logic [7:0] b);
        t_in it;
        it           = scrambled();
        it.func      = FUNC_BYTE;
        it.data_byte = b;
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer(input t_in it);
        while (!calm() && !hold_on && $urandom_range(0, 99) < 15) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_data  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_item(it);
        n_sent++;
        @(negedge clk);
    endtask

    initial begin : stimulus
        t_in it;
        int  n_useful;
        int  dice;
        int  pick;
        int  avail;
        int  c;
        int  k;
        bit  useful;
        in_valid = 1'b0;
        in_data  = '0;
        rst_n    = 1'b0;
        sb       = new;
        n_useful = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        offer(wr_colour(12'h000, 8'hFF));
        offer(wr_colour(12'hFFF, 8'h00));
        offer(wr_colour(12'h0FF, 8'h5A));
        offer(wr_colour(12'hF00, 8'hA5));
        offer(stream_byte(8'hFF));                        // no tile open
        offer(start_tile(MASK_SOLID, ENC_BAD_HI, 4'd0));  // unused layout leaves it idle
        offer(stream_byte(8'h00));
        offer(start_tile(MASK_EMPTY, ENC_SQUARE, 4'd15));
        offer(stream_byte(8'hFF));
        offer(stream_byte(8'h00));
        offer(start_tile(MASK_SOLID, ENC_TRANS, 4'd0));   // abandons the square tile
        offer(stream_byte(8'h80));                        // skip of 128 overruns row 0
        offer(stream_byte(8'h00));                        // zero header
        offer(stream_byte(8'h7F));                        // run of 127 overruns row 1
        offer(stream_byte(8'h00));
        offer(stream_byte(8'hFF));
        offer(start_tile(MASK_SPARE, ENC_LTRI, 4'd0));
        offer(stream_byte(8'h33));                        // pads
        offer(stream_byte(8'hCC));
        offer(stream_byte(8'hFF));
        offer(stream_byte(8'h00));
        offer(start_tile(MASK_WALL, ENC_RTRAP, 4'd15));
        offer(stream_byte(8'h00));
        offer(stream_byte(8'hFF));
        offer(stream_byte(8'h0F));                        // trailing pads
        offer(stream_byte(8'hF0));

        while (n_useful < N_ITEMS) begin
            it   = scrambled();
            dice = $urandom_range(0, 999);
            if (sb.ph != PH_IDLE && tile_left > 0) tile_left--;
            if (sb.ph == PH_IDLE && dice < 100) begin
                it.func = FUNC_TABLE_WR;
            end else if (sb.ph == PH_IDLE && dice < 130) begin
                it.func = FUNC_BYTE;
            end else if (dice >= 985) begin
                it.func = FUNC_UNUSED;
            end else if (sb.ph == PH_IDLE && dice < 150) begin
                it.func     = FUNC_TILE_START;
                it.encoding = $urandom_range(ENC_BAD_LO, ENC_BAD_HI);
            end else if (sb.ph == PH_IDLE || tile_left == 0) begin
                if (sb.colours_per_light[it.light_level] == 0) begin
                    // give the light level a colour before any tile reads it
                    it.func              = FUNC_TABLE_WR;
                    it.table_index[11:8] = it.light_level;
                end else begin
                    it.func = FUNC_TILE_START;
                    if ($urandom_range(0, 99) < 45) it.encoding = ENC_TRANS;
                    else it.encoding = SHAPES[$urandom_range(0, 4)];
                    if ($urandom_range(0, 99) < ((it.encoding == ENC_TRANS) ? 85 : 25))
                        tile_left = 1 << 20;
                    else
                        tile_left = $urandom_range(1, 300);
                end
            end else if (dice < 40) begin
                it.func = FUNC_TABLE_WR;
            end else begin
                it.func = FUNC_BYTE;
                if (sb.ph == PH_PIX) begin
                    // only colours already loaded for this light level
                    c = $urandom_range(0, 255);
                    while (!sb.colour_set[sb.light * 256 + c]) c = (c + 1) % 256;
                    it.data_byte = c[7:0];
                end else if (sb.enc == ENC_TRANS) begin
                    avail = TILE_SIZE - sb.col;
                    pick  = $urandom_range(0, 99);
                    if (pick < 4)
                        it.data_byte = 8'($urandom_range(avail + 1, 127));
                    else if (pick < 8)
                        it.data_byte = 8'(256 - $urandom_range(avail + 1, 128));
                    else if (pick < 13)
                        it.data_byte = 8'd0;
                    else if (pick < 25)
                        it.data_byte = 8'($urandom_range(1, avail));
                    else if (pick < 55)
                        it.data_byte = 8'($urandom_range(1, avail < 6 ? avail : 6));
                    else
                        it.data_byte = 8'(256 - $urandom_range(1, avail));
                end
            end
            useful = !(it.func == FUNC_UNUSED || (it.func == FUNC_BYTE && sb.ph == PH_IDLE));
            offer(it);
            if (useful) n_useful++;
        end
        in_valid <= 1'b0;

        for (k = 0; k < 5000 && sb.due_pixels.size() != 0; k++) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.due_pixels.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.due_pixels.size()));
        if (sb.n_bad == 0)
            $display("masked_tile_decoder_blitter test passed");
        else
            $display("masked_tile_decoder_blitter test failed");
        $finish;
    end

    initial begin : out_stall_gen
        bit held;
        held      = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (!held && n_sent >= 400) begin
                // long hold-off: the queue fills and the input stalls
                held      = 1'b1;
                hold_on   = 1'b1;
                out_stall <= 1'b1;
                repeat (48) @(negedge clk);
                hold_on   = 1'b0;
            end
            out_stall <= !calm() && ($urandom_range(0, 99) < 15);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_pixel(out_data);
    end

    initial begin : watchdog
        #2ms;
        $display("masked_tile_decoder_blitter test failed");
        $finish;
    end

endmodule
